### hdl/prime_sieve_counter_top_assert.svh
// Assertion macros for the checker file of the prime sieve counter.
// Requires a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PRIME_SIEVE_COUNTER_TOP_ASSERT_SVH
`define PRIME_SIEVE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define PSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### hdl/psc_pkg.sv
// Package for the prime sieve counter: sizes, control word and status types,
// and sequencer step indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    localparam int MAX_LIMIT = 65536;
    localparam int MAX_COUNT = 6542;
    localparam int LIMIT_W   = 17;
    localparam int COUNT_W   = 13;
    localparam int ADDR_W    = $clog2(MAX_LIMIT);
    localparam int DEPTH     = 1 << ADDR_W;
    // divisor reaches at most floor(sqrt(MAX_LIMIT)) + 1
    localparam int DIV_W     = 9;
    localparam int SQ_W      = 2 * DIV_W;
    localparam int STEP_W    = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX_VAL = LIMIT_W'(MAX_LIMIT);

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_LIM_LT2,
        COND_N_LT_LIM,
        COND_SQ_GT_LIM,
        COND_BIT_CLR,
        COND_M_NEXT_LE,
        COND_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        CTR_HOLD,
        CTR_LOAD2,
        CTR_INC
    } ctr_op_t;

    typedef enum logic [1:0] {
        M_HOLD,
        M_LOAD2D,
        M_ADDD
    } m_op_t;

    typedef enum logic [1:0] {
        ASEL_N,
        ASEL_D,
        ASEL_M
    } asel_t;

    typedef struct packed {
        logic              take;
        ctr_op_t           n_op;
        ctr_op_t           d_op;
        m_op_t             m_op;
        logic              sq_ld;
        logic              cnt_clr;
        logic              acc;
        logic              mem_we;
        logic              mem_wd;
        logic              mem_re;
        asel_t             asel;
        logic              out_ld;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic lim_lt2;
        logic n_lt_lim;
        logic sq_gt_lim;
        logic bit_clr;
        logic m_next_le;
        logic out_free;
    } stat_t;

    localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_CHECK  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_INIT   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_SQUARE = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_DTEST  = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_SKIP   = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_STRIKE = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_NEXTD  = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_COUNT  = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_END    = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_WAIT   = STEP_W'(11);

endpackage

`default_nettype wire

### hdl/psc_sequencer.sv
// Microcode sequencer: step counter, control ROM and branch evaluation.
// Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psc_sequencer
    import psc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire stat_t stat,
    output ctl_t       ctl
);

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              taken;

    function automatic ctl_t rom_word(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '0;
        w.n_op   = CTR_HOLD;
        w.d_op   = CTR_HOLD;
        w.m_op   = M_HOLD;
        w.asel   = ASEL_N;
        w.cond   = COND_NEVER;
        w.target = STEP_IDLE;
        case (step)
            STEP_IDLE: begin
                w.take    = 1'b1;
                w.n_op    = CTR_LOAD2;
                w.cnt_clr = 1'b1;
                w.cond    = COND_NO_IN;
                w.target  = STEP_IDLE;
            end
            STEP_CHECK: begin
                w.d_op   = CTR_LOAD2;
                w.cond   = COND_LIM_LT2;
                w.target = STEP_END;
            end
            STEP_INIT: begin
                w.mem_we = 1'b1;
                w.mem_wd = 1'b1;
                w.asel   = ASEL_N;
                w.n_op   = CTR_INC;
                w.cond   = COND_N_LT_LIM;
                w.target = STEP_INIT;
            end
            STEP_SQUARE: begin
                w.sq_ld  = 1'b1;
                w.m_op   = M_LOAD2D;
                w.mem_re = 1'b1;
                w.asel   = ASEL_D;
                w.n_op   = CTR_LOAD2;
            end
            STEP_DTEST: begin
                w.cond   = COND_SQ_GT_LIM;
                w.target = STEP_COUNT;
            end
            STEP_SKIP: begin
                w.cond   = COND_BIT_CLR;
                w.target = STEP_NEXTD;
            end
            STEP_STRIKE: begin
                w.mem_we = 1'b1;
                w.mem_wd = 1'b0;
                w.asel   = ASEL_M;
                w.m_op   = M_ADDD;
                w.cond   = COND_M_NEXT_LE;
                w.target = STEP_STRIKE;
            end
            STEP_NEXTD: begin
                w.d_op   = CTR_INC;
                w.cond   = COND_ALWAYS;
                w.target = STEP_SQUARE;
            end
            STEP_COUNT: begin
                w.mem_re = 1'b1;
                w.asel   = ASEL_N;
                w.acc    = 1'b1;
                w.n_op   = CTR_INC;
                w.cond   = COND_N_LT_LIM;
                w.target = STEP_COUNT;
            end
            STEP_LAST: begin
                w.acc = 1'b1;
            end
            STEP_END: begin
                w.out_ld = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
            end
            STEP_WAIT: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_END;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign ctl = rom_word(pc_reg);

    always_comb begin
        case (ctl.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NO_IN:     taken = !s_valid;
            COND_LIM_LT2:   taken = stat.lim_lt2;
            COND_N_LT_LIM:  taken = stat.n_lt_lim;
            COND_SQ_GT_LIM: taken = stat.sq_gt_lim;
            COND_BIT_CLR:   taken = stat.bit_clr;
            COND_M_NEXT_LE: taken = stat.m_next_le;
            COND_OUT_FREE:  taken = stat.out_free;
            default:        taken = 1'b0;
        endcase
        pc_next = taken ? ctl.target : pc_reg + STEP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

### hdl/psc_datapath.sv
// Sieve datapath: limit, number, divisor and multiple registers, candidate
// bit store, prime counter and output register. Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psc_datapath
    import psc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctl_t               ctl,
    input  wire logic               s_valid,
    input  wire logic [LIMIT_W-1:0] s_limit,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic [COUNT_W-1:0]      m_prime_count,
    output stat_t                   stat
);

    logic [LIMIT_W-1:0] lim_reg;
    logic [LIMIT_W-1:0] n_reg;
    logic [DIV_W-1:0]   d_reg;
    logic [LIMIT_W-1:0] m_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               pend_reg;
    logic               rdata_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;

    logic               mem [DEPTH];

    logic               accept;
    logic [LIMIT_W-1:0] sel_val;
    logic [LIMIT_W-1:0] sel_off;
    logic [ADDR_W-1:0]  addr;
    logic [LIMIT_W:0]   m_sum;
    logic [SQ_W-1:0]    sq_full;
    logic               out_free;

    assign accept   = s_valid && ctl.take;
    assign out_free = !m_valid_reg || m_ready;
    assign m_sum    = {1'b0, m_reg} + (LIMIT_W + 1)'(d_reg);
    assign sq_full  = SQ_W'(d_reg) * SQ_W'(d_reg);

    always_comb begin
        case (ctl.asel)
            ASEL_N:  sel_val = n_reg;
            ASEL_D:  sel_val = LIMIT_W'(d_reg);
            ASEL_M:  sel_val = m_reg;
            default: sel_val = n_reg;
        endcase
        sel_off = sel_val - LIMIT_W'(2);
        addr    = sel_off[ADDR_W-1:0];
    end

    assign stat.lim_lt2   = lim_reg < LIMIT_W'(2);
    assign stat.n_lt_lim  = n_reg < lim_reg;
    assign stat.sq_gt_lim = sq_reg > SQ_W'(lim_reg);
    assign stat.bit_clr   = !rdata_reg;
    assign stat.m_next_le = m_sum <= {1'b0, lim_reg};
    assign stat.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (ctl.mem_we) begin
            mem[addr] <= ctl.mem_wd;
        end
        if (ctl.mem_re) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lim_reg <= (s_limit > LIMIT_MAX_VAL) ? LIMIT_MAX_VAL : s_limit;
        end
        case (ctl.n_op)
            CTR_LOAD2: n_reg <= LIMIT_W'(2);
            CTR_INC:   n_reg <= n_reg + LIMIT_W'(1);
            default:   n_reg <= n_reg;
        endcase
        case (ctl.d_op)
            CTR_LOAD2: d_reg <= DIV_W'(2);
            CTR_INC:   d_reg <= d_reg + DIV_W'(1);
            default:   d_reg <= d_reg;
        endcase
        case (ctl.m_op)
            M_LOAD2D: m_reg <= LIMIT_W'({d_reg, 1'b0});
            M_ADDD:   m_reg <= m_sum[LIMIT_W-1:0];
            default:  m_reg <= m_reg;
        endcase
        if (ctl.sq_ld) begin
            sq_reg <= sq_full;
        end
        if (ctl.cnt_clr) begin
            count_reg <= '0;
        end else if (ctl.acc && pend_reg && rdata_reg) begin
            count_reg <= count_reg + COUNT_W'(1);
        end
        if (ctl.out_ld && out_free) begin
            m_count_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= ctl.mem_re;
            if (ctl.out_ld && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_count = m_count_reg;

endmodule

`default_nettype wire

### hdl/prime_sieve_counter_top.sv
// Top level of the prime sieve counter: joins the microcode sequencer and
// the sieve datapath. Depends on psc_pkg, psc_sequencer, psc_datapath.
//
//   channel   dir  ports                              beat
//   s_        in   s_valid s_ready s_limit[16:0]      one limit
//   m_        out  m_valid m_ready m_prime_count[12:0] one prime count
//
// One request holds the sequencer from the accepting cycle through result
// load, for a limit L saturated at 65536; a limit below 2 goes straight to
// result load.
// The single port of the candidate bit store sets the pace: one bit written
// or read per cycle.
// Reset is synchronous, active low; the store needs no clearing after it.
// A result held on m_ stalls only the final step of the next request.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_counter_top
    import psc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [LIMIT_W-1:0] s_limit,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [COUNT_W-1:0]      m_prime_count
);

    ctl_t  ctl;
    stat_t stat;

    psc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctl     (ctl)
    );

    psc_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .s_valid       (s_valid),
        .s_limit       (s_limit),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_prime_count (m_prime_count),
        .stat          (stat)
    );

    assign s_ready = ctl.take;

endmodule

`default_nettype wire

### hdl/psc_checker.sv
// Port-level checks for the prime sieve counter, bound to the top level.
// Depends on psc_pkg and prime_sieve_counter_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "prime_sieve_counter_top_assert.svh"

module psc_checker
    import psc_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [LIMIT_W-1:0] s_limit,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [COUNT_W-1:0] m_prime_count
);

    // hold a waiting request beat
    `PSC_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_limit))
    // hold a stalled result beat
    `PSC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_prime_count))
    // drop ready in the cycle after taking a request
    `PSC_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    // bound the count by the number of primes up to the largest limit
    `PSC_ASSERT_NOW(a_count_range, m_valid, m_prime_count <= COUNT_W'(MAX_COUNT))

endmodule

bind prime_sieve_counter_top psc_checker u_psc_checker (.*);

`default_nettype wire

### sim/tb_prime_sieve_counter_top.sv
// Self-checking testbench for prime_sieve_counter_top: sends limits, predicts
// the prime count with its own sieve, and checks each result beat in order.
// Depends on psc_pkg and the prime_sieve_counter_top RTL.
`timescale 1ns / 1ps

module tb_prime_sieve_counter_top;
    import psc_pkg::*;

    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int SHOWN_ERRORS = 10;
    localparam int BASE_IDLE    = 29;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [LIMIT_W-1:0] s_limit;
    logic               m_valid;
    logic               m_ready;
    logic [COUNT_W-1:0] m_prime_count;

    logic [COUNT_W-1:0] pending_counts[$];
    bit                 struck[0:MAX_LIMIT];
    int                 idle_pct = BASE_IDLE;
    int                 hold_cycles = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    prime_sieve_counter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_limit       (s_limit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_count (m_prime_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [COUNT_W-1:0] prime_tally(input logic [LIMIT_W-1:0] lim);
        int top;
        int tally;
        top   = (int'(lim) > MAX_LIMIT) ? MAX_LIMIT : int'(lim);
        tally = 0;
        if (top >= 2) begin
            for (int n = 2; n <= top; n++)
                struck[n] = 1'b0;
            for (int d = 2; d * d <= top; d++) begin
                if (!struck[d]) begin
                    for (int k = d + d; k <= top; k += d)
                        struck[k] = 1'b1;
                end
            end
            for (int n = 2; n <= top; n++)
                if (!struck[n])
                    tally++;
        end
        return COUNT_W'(tally);
    endfunction

    task automatic report_error(input string what, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("ERROR at %0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    // Call at a falling edge; returns at the falling edge after the beat.
    task automatic send_limit(input logic [LIMIT_W-1:0] lim);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_limit <= lim;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_counts.push_back(prime_tally(lim));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        wait (pending_counts.size() == 0);
        @(negedge aclk);
    endtask

    function automatic logic [LIMIT_W-1:0] random_limit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return LIMIT_W'($urandom_range(3));
        else if (pick < 85)
            return LIMIT_W'($urandom_range(400, 4));
        else if (pick < 97)
            return LIMIT_W'($urandom_range(3000, 401));
        else
            return LIMIT_W'($urandom_range(12000, 3001));
    endfunction

    task automatic test_small_limits();
        logic [LIMIT_W-1:0] edges[$] = '{0, 1, 2, 3, 4, 5, 8, 9, 10, 24, 25, 26,
                                         48, 49, 50, 97, 120, 121, 122, 168, 169};
        foreach (edges[i])
            send_limit(edges[i]);
    endtask

    task automatic test_saturation();
        send_limit(LIMIT_W'(MAX_LIMIT));
        send_limit({LIMIT_W{1'b1}});
    endtask

    task automatic test_backpressure();
        s_valid <= 1'b0;
        @(posedge aclk);
        hold_cycles = 600;
        @(negedge aclk);
        for (int i = 0; i < 6; i++)
            send_limit(LIMIT_W'($urandom_range(40, 2)));
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++)
            send_limit(random_limit());
        drain_results();
        for (int i = 0; i < 4; i++)
            send_limit(random_limit());
    endtask

    task automatic test_streaming();
        idle_pct = 0;
        for (int i = 0; i < 20; i++)
            send_limit(LIMIT_W'($urandom_range(200)));
        idle_pct = BASE_IDLE;
    endtask

    task automatic test_random();
        for (int i = 0; i < 45; i++)
            send_limit(random_limit());
    endtask

    // Receiver: hold off on request, otherwise stall at random.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        logic [COUNT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                report_error("unexpected prime_count beat", '0, m_prime_count);
            end else begin
                want = pending_counts.pop_front();
                if (m_prime_count !== want)
                    report_error("prime_count", want, m_prime_count);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_limit = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_small_limits();
        test_saturation();
        test_backpressure();
        test_drain_pause();
        test_streaming();
        test_random();

        drain_results();
        repeat (20) @(posedge aclk);
        if (pending_counts.size() != 0)
            report_error("results missing at end", '0, '0);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
